@@ src/nbc_pkg.sv @@
package nbc_pkg;

  // model dimensions
  localparam int FEATURES   = 192;
  localparam int VALUES     = 5;
  localparam int CLASSES    = 10;
  localparam int COUNT_BITS = 13;

  // fixed field widths of the stream payload
  localparam int FIDX_W      = 8;
  localparam int FVAL_W      = 3;
  localparam int LBL_W       = 4;
  localparam int PRED_W      = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam int STORE_DEPTH = FEATURES * VALUES * CLASSES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLS_W       = $clog2(CLASSES);

  // log2 in q.10, computed by repeated squaring of a q1.30 mantissa
  localparam int FRAC_BITS = 11;
  localparam int MANT_W    = 31;
  localparam int E_W       = $clog2(COUNT_BITS);
  localparam int ITER_W    = $clog2(FRAC_BITS);
  localparam int LOG_W     = $clog2(COUNT_BITS * 1024 + 1);
  localparam int R_W       = LOG_W + 1;
  localparam int TERM_W    = LOG_W + 1;

  localparam int SCORE_W = 26;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [LOG_W-1:0]         log_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [TERM_W-1:0]  term_t;

  typedef struct packed {
    logic   start;
    count_t n;
  } log_req_t;

  typedef struct packed {
    logic done;
    log_t res;
  } log_rsp_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + count_t'(1);
  endfunction

  // score plus term, clamped to the signed score range
  function automatic score_t sat_add(input score_t a, input term_t b);
    logic signed [SCORE_W:0] s;
    s = $signed({a[SCORE_W-1], a}) + (SCORE_W+1)'(b);
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      sat_add = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sat_add = s[SCORE_W-1:0];
    end
  endfunction

endpackage

@@ src/nbc_log.sv @@
module nbc_log import nbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  log_req_t req,
  output log_rsp_t rsp
);

  logic                     active_r;
  logic                     done_r;
  logic [ITER_W-1:0]        iter_r;
  logic [MANT_W-1:0]        m_r;
  logic [FRAC_BITS-1:0]     frac_r;
  logic [E_W-1:0]           e_r;
  log_t                     res_r;

  logic [E_W-1:0]                   e_in;
  logic [COUNT_BITS+MANT_W-2:0]     shifted;
  logic [2*MANT_W-1:0]              prod;
  logic [MANT_W:0]                  q;
  logic [MANT_W-1:0]                m_nxt;
  logic [FRAC_BITS-1:0]             frac_nxt;
  logic [R_W-1:0]                   r;
  log_t                             res_nxt;

  always_comb begin
    e_in = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (req.n[i]) begin
        e_in = E_W'(i);
      end
    end
    // normalize so the top bit lands on the q1.30 integer bit
    shifted  = {req.n, {(MANT_W-1){1'b0}}} >> e_in;
    prod     = (2*MANT_W)'(m_r) * (2*MANT_W)'(m_r);
    q        = prod[2*MANT_W-1:MANT_W-1];
    m_nxt    = q[MANT_W] ? q[MANT_W:1] : q[MANT_W-1:0];
    frac_nxt = {frac_r[FRAC_BITS-2:0], q[MANT_W]};
    r        = (R_W'(e_r) << FRAC_BITS) + R_W'(frac_nxt) + R_W'(1);
    res_nxt  = LOG_W'(r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      iter_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !active_r) begin
        if (req.n == '0) begin
          done_r <= 1'b1;
          res_r  <= '0;
        end else begin
          active_r <= 1'b1;
          iter_r   <= '0;
          e_r      <= e_in;
          m_r      <= shifted[MANT_W-1:0];
          frac_r   <= '0;
        end
      end else if (active_r) begin
        m_r    <= m_nxt;
        frac_r <= frac_nxt;
        iter_r <= iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(FRAC_BITS - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
          res_r    <= res_nxt;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

@@ src/naive_bayes_classifier_unit.sv @@
// Categorical naive Bayes classifier. After reset the count memory is swept to zero, all
// STORE_DEPTH entries (9600), with in_tready low. Training beats (tuser 0) with label,
// feature and value in range bump the count for their feature, value and label; a
// training beat with tlast and an in-range label also bumps the class and sample totals
// and refreshes their cached log2 values through the shared log2 unit. A classification
// beat (tuser 1) with feature and value in range walks the classes one at a time through
// the count memory and the log2 unit; a class with a zero count is excluded and skips
// the log2 unit. With tlast a final pass through S_F_ADD and S_F_CMP for each class adds
// the priors and picks the best class, then one result beat is issued. The log2 unit (one
// squaring per cycle for 11 fraction bits) sets the pace.
module naive_bayes_classifier_unit import nbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // feature_index, feature_value, class_label
  input  logic                   in_tuser,   // mode
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // predicted_class
  output logic                   out_tuser   // all_excluded
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_T_RD    = 4'd2;
  localparam logic [3:0] S_T_WR    = 4'd3;
  localparam logic [3:0] S_T_TOT   = 4'd4;
  localparam logic [3:0] S_T_LTOT  = 4'd5;
  localparam logic [3:0] S_T_LSAMP = 4'd6;
  localparam logic [3:0] S_C_RD    = 4'd7;
  localparam logic [3:0] S_C_CHK   = 4'd8;
  localparam logic [3:0] S_C_LOG   = 4'd9;
  localparam logic [3:0] S_C_ADD   = 4'd10;
  localparam logic [3:0] S_F_ADD   = 4'd11;
  localparam logic [3:0] S_F_CMP   = 4'd12;
  localparam logic [3:0] S_F_OUT   = 4'd13;

  localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(CLASSES - 1);

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic              last_r, last_nxt;
  count_t            samp_r, samp_nxt;
  log_t              lsamp_r, lsamp_nxt;
  log_t              lcnt_r, lcnt_nxt;
  score_t            s_r, s_nxt;
  score_t            best_s_r, best_s_nxt;
  logic [CLS_W-1:0]  best_c_r, best_c_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PRED_W-1:0] out_pred_r, out_pred_nxt;
  logic              out_excl_r, out_excl_nxt;

  count_t            tot_r   [CLASSES];
  log_t              ltot_r  [CLASSES];
  score_t            score_r [CLASSES];
  logic [CLASSES-1:0] excl_r;

  count_t            mem [STORE_DEPTH];
  count_t            rdata_r;

  logic [FIDX_W-1:0] in_fidx;
  logic [FVAL_W-1:0] in_fval;
  logic [LBL_W-1:0]  in_lbl;
  logic              in_feat_ok;
  logic              in_lbl_ok;
  logic [ADDR_W-1:0] in_base;
  logic [ADDR_W-1:0] acc_addr;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_we;
  count_t            mem_wdata;
  log_t              term_lhs, term_rhs;
  term_t             term;
  score_t            sum;
  log_req_t          log_req;
  log_rsp_t          log_rsp;

  nbc_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (log_req),
    .rsp   (log_rsp)
  );

  assign in_fidx    = in_tdata[FIDX_W-1:0];
  assign in_fval    = in_tdata[FIDX_W+FVAL_W-1:FIDX_W];
  assign in_lbl     = in_tdata[FIDX_W+FVAL_W+LBL_W-1:FIDX_W+FVAL_W];
  assign in_feat_ok = (32'(in_fidx) < FEATURES) && (32'(in_fval) < VALUES);
  assign in_lbl_ok  = 32'(in_lbl) < CLASSES;
  assign in_base    = ADDR_W'((32'(in_fidx) * VALUES + 32'(in_fval)) * CLASSES);
  assign acc_addr   = base_r + ADDR_W'(cls_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-PRED_W){1'b0}}, out_pred_r};
  assign out_tuser  = out_excl_r;

  // shared subtract and saturating add: likelihood term or prior
  always_comb begin
    term_lhs = (state_r == S_C_ADD) ? lcnt_r : ltot_r[cls_r];
    term_rhs = (state_r == S_C_ADD) ? ltot_r[cls_r] : lsamp_r;
    term     = $signed({1'b0, term_lhs}) - $signed({1'b0, term_rhs});
    sum      = sat_add(score_r[cls_r], term);
  end

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_T_WR);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : acc_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? count_t'(0) : sat_inc(rdata_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[acc_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    base_nxt      = base_r;
    cls_nxt       = cls_r;
    last_nxt      = last_r;
    samp_nxt      = samp_r;
    lsamp_nxt     = lsamp_r;
    lcnt_nxt      = lcnt_r;
    s_nxt         = s_r;
    best_s_nxt    = best_s_r;
    best_c_nxt    = best_c_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pred_nxt  = out_pred_r;
    out_excl_nxt  = out_excl_r;
    log_req.start = 1'b0;
    log_req.n     = samp_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          base_nxt = in_base;
          last_nxt = in_tlast;
          if (!in_tuser) begin
            cls_nxt = in_lbl_ok ? CLS_W'(in_lbl) : '0;
            priority if (!in_lbl_ok) begin
              state_nxt = S_IDLE;
            end else if (in_feat_ok) begin
              state_nxt = S_T_RD;
            end else if (in_tlast) begin
              state_nxt = S_T_TOT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            cls_nxt = '0;
            priority if (in_feat_ok) begin
              state_nxt = S_C_RD;
            end else if (in_tlast) begin
              state_nxt = S_F_ADD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_T_RD: begin
        state_nxt = S_T_WR;
      end
      S_T_WR: begin
        state_nxt = last_r ? S_T_TOT : S_IDLE;
      end
      S_T_TOT: begin
        samp_nxt      = sat_inc(samp_r);
        log_req.start = 1'b1;
        log_req.n     = sat_inc(tot_r[cls_r]);
        state_nxt     = S_T_LTOT;
      end
      S_T_LTOT: begin
        if (log_rsp.done) begin
          log_req.start = 1'b1;
          state_nxt     = S_T_LSAMP;
        end
      end
      S_T_LSAMP: begin
        if (log_rsp.done) begin
          lsamp_nxt = log_rsp.res;
          state_nxt = S_IDLE;
        end
      end
      S_C_RD: begin
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        if (rdata_r == '0) begin
          if (cls_r == LAST_CLS) begin
            cls_nxt   = '0;
            state_nxt = last_r ? S_F_ADD : S_IDLE;
          end else begin
            cls_nxt   = cls_r + CLS_W'(1);
            state_nxt = S_C_RD;
          end
        end else begin
          log_req.start = 1'b1;
          log_req.n     = rdata_r;
          state_nxt     = S_C_LOG;
        end
      end
      S_C_LOG: begin
        if (log_rsp.done) begin
          lcnt_nxt  = log_rsp.res;
          state_nxt = S_C_ADD;
        end
      end
      S_C_ADD: begin
        if (cls_r == LAST_CLS) begin
          cls_nxt   = '0;
          state_nxt = last_r ? S_F_ADD : S_IDLE;
        end else begin
          cls_nxt   = cls_r + CLS_W'(1);
          state_nxt = S_C_RD;
        end
      end
      S_F_ADD: begin
        s_nxt     = sum;
        state_nxt = S_F_CMP;
      end
      S_F_CMP: begin
        if (!excl_r[cls_r] && (!found_r || s_r > best_s_r)) begin
          found_nxt  = 1'b1;
          best_s_nxt = s_r;
          best_c_nxt = cls_r;
        end
        if (cls_r == LAST_CLS) begin
          cls_nxt   = '0;
          state_nxt = S_F_OUT;
        end else begin
          cls_nxt   = cls_r + CLS_W'(1);
          state_nxt = S_F_ADD;
        end
      end
      S_F_OUT: begin
        // hold here while the previous result beat is still waiting
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = PRED_W'(best_c_r);
          out_excl_nxt  = !found_r;
          found_nxt     = 1'b0;
          best_c_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cls_r       <= '0;
      last_r      <= 1'b0;
      samp_r      <= '0;
      lsamp_r     <= '0;
      found_r     <= 1'b0;
      best_c_r    <= '0;
      out_valid_r <= 1'b0;
      excl_r      <= '0;
      for (int i = 0; i < CLASSES; i++) begin
        tot_r[i]   <= '0;
        ltot_r[i]  <= '0;
        score_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cls_r       <= cls_nxt;
      last_r      <= last_nxt;
      samp_r      <= samp_nxt;
      lsamp_r     <= lsamp_nxt;
      found_r     <= found_nxt;
      best_c_r    <= best_c_nxt;
      out_valid_r <= out_valid_nxt;

      if (state_r == S_T_TOT) begin
        tot_r[cls_r] <= sat_inc(tot_r[cls_r]);
      end
      if ((state_r == S_T_LTOT) && log_rsp.done) begin
        ltot_r[cls_r] <= log_rsp.res;
      end
      if ((state_r == S_C_CHK) && (rdata_r == '0)) begin
        excl_r[cls_r] <= 1'b1;
      end
      if ((state_r == S_F_ADD) && (tot_r[cls_r] == '0)) begin
        excl_r[cls_r] <= 1'b1;
      end
      if (state_r == S_C_ADD) begin
        score_r[cls_r] <= sum;
      end
      if ((state_r == S_F_OUT) && (!out_valid_r || out_tready)) begin
        excl_r <= '0;
        for (int i = 0; i < CLASSES; i++) begin
          score_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    lcnt_r     <= lcnt_nxt;
    s_r        <= s_nxt;
    best_s_r   <= best_s_nxt;
    out_pred_r <= out_pred_nxt;
    out_excl_r <= out_excl_nxt;
  end

  // log2 results only come back while the sequencer waits for one
  a_log_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    log_rsp.done |-> (state_r == S_T_LTOT || state_r == S_T_LSAMP || state_r == S_C_LOG))
    else $error("log2 result arrived outside a wait state");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_F_OUT))
    else $error("result beat raised outside the final pass");

  a_flags_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (excl_r == '0 && !found_r))
    else $error("classification state not cleared with the result");

  a_sample_covers_class: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tot_r[cls_r] <= samp_r))
    else $error("class total exceeds sample total");

endmodule

@@ sim/nbc_tb_pkg.sv @@
`timescale 1ns / 100ps

package nbc_tb_pkg;

  // what the in_tuser bit says about a beat
  typedef enum logic {
    MODE_TRAIN    = 1'b0,
    MODE_CLASSIFY = 1'b1
  } nbc_mode_e;

endpackage

@@ sim/nbc_checker.sv @@
`timescale 1ns / 100ps

module nbc_checker import nbc_pkg::*, nbc_tb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic [PRED_W-1:0] cls;
    logic              none;
  } verdict_t;

  // own copy of the classifier state
  int unsigned      value_tally [STORE_DEPTH];
  int unsigned      class_tally [CLASSES];
  int unsigned      sample_tally = 0;
  int               score [CLASSES];
  logic [CLASSES-1:0] excluded = '0;

  verdict_t verdict_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (score[c]) score[c] = 0;
  end

  function automatic int unsigned count_up(input int unsigned n);
    return (n >= int'(COUNT_MAX)) ? int'(COUNT_MAX) : n + 1;
  endfunction

  function automatic int score_sum(input int a, input int b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 33554431) s = 33554431;
    if (s < -33554432) s = -33554432;
    return int'(s);
  endfunction

  // log2 in q.10, fraction bits by repeated squaring of a q1.30 mantissa, rounded half up
  function automatic int log2_fix(input int unsigned n);
    int unsigned e;
    int unsigned frac;
    int          i;
    longint unsigned m;
    n = n & 32'hffff;
    if (n == 0) return 0;
    e = 0;
    while ((n >> (e + 1)) != 0) e++;
    m = 64'(n) << (30 - e);
    frac = 0;
    for (i = 0; i < 11; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return int'((e * 2048 + frac + 1) >> 1);
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int       f, v, lbl, base, c, s, best, best_c;
    bit       known, found;
    verdict_t want;
    if (rst_n) begin
      // result side first: a beat accepted at this edge cannot have caused it
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result beat class %0d with nothing expected",
                                    out_tdata[PRED_W-1:0]));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[PRED_W-1:0] !== want.cls)
            report_mismatch($sformatf("predicted_class %0d, expected %0d",
                                      out_tdata[PRED_W-1:0], want.cls));
          if (out_tuser !== want.none)
            report_mismatch($sformatf("all_excluded %b, expected %b", out_tuser, want.none));
        end
      end

      if (in_tvalid && in_tready) begin
        f     = in_tdata[FIDX_W-1:0];
        v     = in_tdata[FIDX_W +: FVAL_W];
        lbl   = in_tdata[FIDX_W+FVAL_W +: LBL_W];
        known = (f < FEATURES) && (v < VALUES);
        base  = (f * VALUES + v) * CLASSES;
        if (in_tuser == MODE_TRAIN) begin
          if (lbl < CLASSES) begin
            if (known) value_tally[base+lbl] = count_up(value_tally[base+lbl]);
            if (in_tlast) begin
              class_tally[lbl] = count_up(class_tally[lbl]);
              sample_tally = count_up(sample_tally);
            end
          end
        end else begin
          if (known) begin
            for (c = 0; c < CLASSES; c++) begin
              if (value_tally[base+c] == 0) begin
                excluded[c] = 1'b1;
              end else begin
                score[c] = score_sum(score[c],
                  log2_fix(value_tally[base+c]) - log2_fix(class_tally[c]));
              end
            end
          end
          if (in_tlast) begin
            found  = 1'b0;
            best   = 0;
            best_c = 0;
            for (c = 0; c < CLASSES; c++) begin
              if (class_tally[c] == 0) excluded[c] = 1'b1;
              if (!excluded[c]) begin
                s = score_sum(score[c], log2_fix(class_tally[c]) - log2_fix(sample_tally));
                if (!found || s > best) begin
                  found  = 1'b1;
                  best   = s;
                  best_c = c;
                end
              end
            end
            want.cls  = PRED_W'(best_c);
            want.none = !found;
            verdict_q.push_back(want);
            foreach (score[k]) score[k] = 0;
            excluded = '0;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top import nbc_pkg::*, nbc_tb_pkg::*; ();

  localparam int CYCLE_LIMIT = 4_000_000;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int fail_count;
  int pending;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int beats_sent   = 0;
  int cycle_cnt    = 0;

  naive_bayes_classifier_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  nbc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // called at a falling edge, returns at a falling edge with the beat taken
  task automatic send_beat(input nbc_mode_e mode, input int f, input int v, input int lbl,
                           input bit last);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= last;
    in_tdata  <= {1'b0, LBL_W'(lbl), FVAL_W'(v), FIDX_W'(f)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (!(mode == MODE_TRAIN && lbl >= CLASSES)) beats_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly whole samples over a small feature pool, with stray beats mixed in
  task automatic random_traffic(input int quota);
    int        start, len, f, v, lbl, k, i;
    nbc_mode_e mode;
    start = beats_sent;
    while (beats_sent - start < quota) begin
      k = $urandom_range(99);
      if (k < 8) begin
        send_beat(nbc_mode_e'($urandom_range(1)), $urandom_range(255), $urandom_range(7),
                  $urandom_range(15), $urandom_range(1));
      end else begin
        mode = (k < 55) ? MODE_TRAIN : MODE_CLASSIFY;
        lbl  = $urandom_range(CLASSES - 1);
        len  = $urandom_range(6, 1);
        for (i = 0; i < len; i++) begin
          f = $urandom_range(7);
          // values lean on the class so that predictions differ
          v = ($urandom_range(9) < 6) ? (lbl * 3 + f) % VALUES : $urandom_range(VALUES - 1);
          if ($urandom_range(19) == 0) begin
            f = $urandom_range(255);
            v = $urandom_range(7);
          end
          send_beat(mode, f, v, (mode == MODE_TRAIN) ? lbl : $urandom_range(15), i == len - 1);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty model: everything excluded
    send_beat(MODE_CLASSIFY, 0, 0, 0, 1'b1);
    send_beat(MODE_CLASSIFY, 255, 7, 15, 1'b1);
    send_beat(MODE_TRAIN, FEATURES - 1, VALUES - 1, CLASSES - 1, 1'b1);
    send_beat(MODE_TRAIN, 0, 0, 0, 1'b1);
    send_beat(MODE_TRAIN, 0, 0, 0, 1'b0);
    // feature or value out of range still counts the sample
    send_beat(MODE_TRAIN, 255, 7, 3, 1'b1);
    send_beat(MODE_TRAIN, 12, 5, 2, 1'b1);
    // labels out of range are dropped
    send_beat(MODE_TRAIN, 5, 1, 15, 1'b1);
    send_beat(MODE_TRAIN, 5, 1, 10, 1'b0);
    send_beat(MODE_CLASSIFY, FEATURES - 1, VALUES - 1, 6, 1'b1);
    send_beat(MODE_CLASSIFY, 200, 0, 0, 1'b1);
    // training in the middle of a classification
    send_beat(MODE_CLASSIFY, 0, 0, 9, 1'b0);
    send_beat(MODE_TRAIN, 0, 0, 1, 1'b1);
    send_beat(MODE_CLASSIFY, FEATURES - 1, VALUES - 1, 0, 1'b1);
    send_beat(MODE_CLASSIFY, 0, 0, 3, 1'b1);
    send_beat(MODE_CLASSIFY, 0, 6, 12, 1'b0);
    send_beat(MODE_CLASSIFY, 0, 0, 0, 1'b1);
    drain();

    random_traffic(450);
    drain();

    tx_gap_pct = 81;
    random_traffic(450);
    drain();

    tx_gap_pct   = 0;
    rx_stall_pct = 81;
    random_traffic(450);
    drain();

    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    random_traffic(450);
    drain();

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    random_traffic(80);
    drain();

    repeat (400) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/nbc_pkg.sv
src/nbc_log.sv
src/naive_bayes_classifier_unit.sv
sim/nbc_tb_pkg.sv
sim/nbc_checker.sv
sim/tb_top.sv
